// ===== rtl/core/wsuri_pkg.sv =====
// ----------------------------------------------------------------------------
// wsuri_pkg
// Types, character codes and the host character class that the WebSocket
// URI checker uses.
// ----------------------------------------------------------------------------
package wsuri_pkg;

  typedef logic [7:0] char_t;

  typedef enum logic [3:0] {
    PH_W     = 4'd0,  // expecting 'w'
    PH_S1    = 4'd1,  // expecting 's'
    PH_S2    = 4'd2,  // expecting 's' (wss) or ':' (ws)
    PH_COLON = 4'd3,  // expecting ':' after "wss"
    PH_SL1   = 4'd4,  // expecting first '/'
    PH_SL2   = 4'd5,  // expecting second '/'
    PH_HOST  = 4'd6,
    PH_PORT  = 4'd7,
    PH_REST  = 4'd8,  // after '/', any byte is accepted
    PH_FAIL  = 4'd9
  } phase_t;

  localparam char_t CH_W     = 8'h77;  // 'w'
  localparam char_t CH_S     = 8'h73;  // 's'
  localparam char_t CH_COLON = 8'h3a;  // ':'
  localparam char_t CH_SLASH = 8'h2f;  // '/'
  localparam char_t CH_DASH  = 8'h2d;  // '-'
  localparam char_t CH_DOT   = 8'h2e;  // '.'
  localparam char_t CH_LC_A  = 8'h61;
  localparam char_t CH_LC_Z  = 8'h7a;
  localparam char_t CH_UC_A  = 8'h41;
  localparam char_t CH_UC_Z  = 8'h5a;
  localparam char_t CH_D0    = 8'h30;
  localparam char_t CH_D9    = 8'h39;

  function automatic logic is_digit(input char_t c);
    return (c >= CH_D0) && (c <= CH_D9);
  endfunction

  function automatic logic is_host_char(input char_t c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
           is_digit(c) || (c == CH_DASH) || (c == CH_DOT);
  endfunction

endpackage

// ===== rtl/core/websocket_uri_checker.sv =====
// ----------------------------------------------------------------------------
// websocket_uri_checker
// Byte-serial syntax check of a ws:// or wss:// URI with a verdict per string.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | direction | beats
//  --------+----------------------------------------+-----------+-------------------
//  in      | in_valid in_stall in_char_byte         | sink      | one per URI byte
//          | in_final_char                          |           |
//  out     | out_valid out_stall out_uri_ok         | source    | one per URI, after
//          | out_secure_scheme                      |           | the final byte
//
// One byte is taken per cycle while in_stall is low; the parse phase register
// and the host and secure flags loop back. The verdict of a string appears in the cycle after its final byte.
// rst_n is synchronous and returns the parser to the start of a string and
// empties the result register.
// in_stall is raised only while a verdict waits in the result register and
// out_stall holds it there.
// ----------------------------------------------------------------------------
module websocket_uri_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wsuri_pkg::char_t     in_char_byte,
  input  logic                 in_final_char,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_uri_ok,
  output logic                 out_secure_scheme
);
  import wsuri_pkg::*;

  phase_t phase_r, phase_nxt, adv_phase;
  logic   host_seen_r, host_seen_nxt, adv_host;
  logic   secure_r, secure_nxt, adv_secure;
  logic   out_valid_r, out_valid_nxt;
  logic   uri_ok_r, uri_ok_nxt;
  logic   sec_out_r, sec_out_nxt;
  logic   in_accept;
  logic   last_beat;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign last_beat = in_accept && in_final_char;

  // Phase advance for one byte.
  always_comb begin
    adv_phase = phase_r;
    unique case (phase_r)
      PH_W:     adv_phase = (in_char_byte == CH_W) ? PH_S1 : PH_FAIL;
      PH_S1:    adv_phase = (in_char_byte == CH_S) ? PH_S2 : PH_FAIL;
      PH_S2: begin
        if (in_char_byte == CH_S) begin
          adv_phase = PH_COLON;
        end else if (in_char_byte == CH_COLON) begin
          adv_phase = PH_SL1;
        end else begin
          adv_phase = PH_FAIL;
        end
      end
      PH_COLON: adv_phase = (in_char_byte == CH_COLON) ? PH_SL1 : PH_FAIL;
      PH_SL1:   adv_phase = (in_char_byte == CH_SLASH) ? PH_SL2 : PH_FAIL;
      PH_SL2:   adv_phase = (in_char_byte == CH_SLASH) ? PH_HOST : PH_FAIL;
      PH_HOST: begin
        if (in_char_byte == CH_COLON || in_char_byte == CH_SLASH) begin
          if (!host_seen_r) begin
            adv_phase = PH_FAIL;
          end else begin
            adv_phase = (in_char_byte == CH_COLON) ? PH_PORT : PH_REST;
          end
        end else if (!is_host_char(in_char_byte)) begin
          adv_phase = PH_FAIL;
        end
      end
      PH_PORT: begin
        if (in_char_byte == CH_SLASH) begin
          adv_phase = PH_REST;
        end else if (!is_digit(in_char_byte)) begin
          adv_phase = PH_FAIL;
        end
      end
      PH_REST:  adv_phase = PH_REST;
      default:  adv_phase = PH_FAIL;
    endcase
  end

  // Flags and verdict that follow from the advance.
  always_comb begin
    adv_host   = host_seen_r;
    adv_secure = secure_r;
    if (phase_r == PH_HOST && is_host_char(in_char_byte)) begin
      adv_host = 1'b1;
    end
    if (phase_r == PH_S2 && in_char_byte == CH_S) begin
      adv_secure = 1'b1;
    end
    // A failure inside the scheme also drops the secure flag.
    if (phase_r <= PH_SL2 && adv_phase == PH_FAIL) begin
      adv_secure = 1'b0;
    end

    case (adv_phase)
      PH_HOST:          uri_ok_nxt = adv_host;
      PH_PORT, PH_REST: uri_ok_nxt = 1'b1;
      default:          uri_ok_nxt = 1'b0;
    endcase
    // A string that ends inside the scheme is never reported as secure.
    sec_out_nxt = (adv_phase <= PH_SL2) ? 1'b0 : adv_secure;

    phase_nxt     = phase_r;
    host_seen_nxt = host_seen_r;
    secure_nxt    = secure_r;
    if (last_beat) begin
      phase_nxt     = PH_W;
      host_seen_nxt = 1'b0;
      secure_nxt    = 1'b0;
    end else if (in_accept) begin
      phase_nxt     = adv_phase;
      host_seen_nxt = adv_host;
      secure_nxt    = adv_secure;
    end

    out_valid_nxt = last_beat || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_W;
      host_seen_r <= 1'b0;
      secure_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      host_seen_r <= host_seen_nxt;
      secure_r    <= secure_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (last_beat) begin
      uri_ok_r  <= uri_ok_nxt;
      sec_out_r <= sec_out_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_uri_ok        = uri_ok_r;
  assign out_secure_scheme = sec_out_r;

  // After a final byte the parser is back at the start of a string.
  assert property (@(posedge clk) disable iff (!rst_n)
    last_beat |=> (phase_r == PH_W && !host_seen_r && !secure_r))
    else $error("parser not restarted after final byte");

  // A verdict only appears after a final byte was taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(last_beat))
    else $error("verdict without final byte");

  // Port or path phases can only be reached through a non-empty host.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PORT || phase_r == PH_REST) |-> host_seen_r)
    else $error("port or path reached with empty host");

  // No host byte can have been seen while still inside the scheme.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r <= PH_SL2) |-> !host_seen_r)
    else $error("host flag set inside scheme");

endmodule
